// File: rtl/mbt_pkg.sv
package mbt_pkg;

    typedef enum logic [1:0] {
        OP_MARK_NEW   = 2'd0,
        OP_MARK_BLOCK = 2'd1,
        OP_LOOKUP     = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_SLOTS_FULL = 2'd2
    } status_t;

    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned BIT_SEL_W = 6;

    // The block number is split by bit slicing, so this stays a power of two.
    localparam int BLOCKS_PER_CONTAINER = 1024;

endpackage

// File: rtl/modified_block_tracker.sv
// Channel   Direction  Handshake                  Payload (tdata, lowest bits first)
// s_axis    in         s_tvalid / s_tready        operation, tablespace_id, database_id,
//                                                 relation_number, fork_req, block_number
// m_axis    out        m_tvalid / m_tready        status, found_before, is_new,
//                                                 already_marked, container_blocks,
//                                                 entry_containers, table_entries
//
// One item at a time. The entry search reads and then compares each entry in turn, and a
// lookup or mark_new ends after that search. A block mark on an entry not marked new then
// searches the entry's containers (read, compare), clears the WPS bitmap words of a new
// container when the container is missing, and reads and updates the bitmap word.
// Reset is synchronous; after reset the block is ready at once.
// The result sits in an output register; s_tready returns the cycle after the result
// transfer, so a stalled sink holds the block.
module modified_block_tracker #(
    parameter int MAX_ENTRIES          = 32,
    parameter int MAX_CONTAINERS       = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], tablespace_id[33:2], database_id[65:34], relation_number[97:66],
    // fork_req[99:98], block_number[131:100], zero fill [135:132]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], found_before[2], is_new[3], already_marked[4],
    // container_blocks[15:5], entry_containers[19:16], table_entries[25:20], zero [31:26]
    output logic [31:0]  m_tdata
);

    localparam int BPC   = mbt_pkg::BLOCKS_PER_CONTAINER;
    localparam int WBITS = mbt_pkg::WORD_BITS;
    localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ECW   = $clog2(MAX_ENTRIES + 1);
    localparam int CCW   = $clog2(MAX_CONTAINERS + 1);
    localparam int BPW   = $clog2(BPC);
    localparam int BCW   = $clog2(BPC + 1);
    localparam int WPS   = (BPC + WBITS - 1) / WBITS;
    localparam int WCW   = $clog2(WPS + 1);
    localparam int NSLOT = MAX_ENTRIES * MAX_CONTAINERS;
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int NWORD = NSLOT * WPS;
    localparam int AW    = (NWORD > 1) ? $clog2(NWORD) : 1;
    localparam int CNW   = 32 - BPW;
    localparam int KW    = 98;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_ESCAN  = 11'b00000000010,
        S_ECHK   = 11'b00000000100,
        S_EREAD  = 11'b00000001000,
        S_EDEC   = 11'b00000010000,
        S_CSCAN  = 11'b00000100000,
        S_CCHK   = 11'b00001000000,
        S_CLEAR  = 11'b00010000000,
        S_WREAD  = 11'b00100000000,
        S_WMOD   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [KW-1:0]   key_mem [MAX_ENTRIES];
    logic            newf_mem [MAX_ENTRIES];
    logic [CCW-1:0]  ccnt_mem [MAX_ENTRIES];
    logic [CNW-1:0]  cno_mem [NSLOT];
    logic [BCW-1:0]  bcnt_mem [NSLOT];
    logic [63:0]     bmp_mem [NWORD];
    logic [MAX_ENTRIES-1:0] valid_reg;

    logic [1:0]     op_reg;
    logic [KW-1:0]  key_reg;
    logic [31:0]    blk_reg;
    logic [ECW-1:0] total_reg;
    logic [ECW-1:0] idx_reg;
    logic [EW-1:0]  ent_reg;
    logic           found_reg;
    logic [KW-1:0]  key_rd;
    logic           newf_rd;
    logic [CCW-1:0] ccnt_rd;
    logic [CNW-1:0] cno_rd;
    logic [BCW-1:0] bcnt_rd;
    logic [63:0]    word_rd;
    logic [CCW-1:0] ccnt_reg;
    logic [CCW-1:0] k_reg;
    logic [SW-1:0]  slot_reg;
    logic [WCW-1:0] wc_reg;
    logic [31:0]    res_reg;
    logic           out_valid_reg;

    logic [EW-1:0]  free_idx;
    logic           free_any;
    logic [SW-1:0]  slot_rd_addr;
    logic [AW-1:0]  word_addr;
    logic [CNW-1:0] cno_in;
    logic [BPW-1:0] off_in;

    assign cno_in = blk_reg[31:BPW];
    assign off_in = blk_reg[BPW-1:0];

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = EW'(i);
                free_any = 1'b1;
            end
        end
    end

    function automatic logic [31:0] pack_res(
        input logic [1:0] st, input logic fb, input logic nw, input logic am,
        input logic [BCW-1:0] cb, input logic [CCW-1:0] ec, input logic [ECW-1:0] te);
        logic [31:0] r;
        r = '0;
        r[1:0]   = st;
        r[2]     = fb;
        r[3]     = nw;
        r[4]     = am;
        r[15:5]  = 11'(cb);
        r[19:16] = 4'(ec);
        r[25:20] = 6'(te);
        return r;
    endfunction

    assign slot_rd_addr = SW'(ent_reg) * SW'(MAX_CONTAINERS) + SW'(k_reg);
    always_comb begin
        word_addr = AW'(slot_reg) * AW'(WPS);
        if (state_reg == S_CLEAR) begin
            word_addr = word_addr + AW'(wc_reg);
        end else if (WPS > 1) begin
            word_addr = word_addr + AW'(off_in >> mbt_pkg::BIT_SEL_W);
        end
    end

    // Memory reads are registered.
    always_ff @(posedge aclk) begin
        key_rd  <= key_mem[idx_reg[EW-1:0]];
        newf_rd <= newf_mem[ent_reg];
        ccnt_rd <= ccnt_mem[ent_reg];
        cno_rd  <= cno_mem[slot_rd_addr];
        bcnt_rd <= bcnt_mem[slot_reg];
        word_rd <= bmp_mem[word_addr];
    end

    logic key_wr, flag_wr, ccnt_wr, cno_wr, bcnt_wr, bmp_wr;
    logic [CCW-1:0] ccnt_wdata;
    logic [BCW-1:0] bcnt_wdata;
    logic [63:0]    bmp_wdata;
    logic           flag_wdata;

    always_ff @(posedge aclk) begin
        if (key_wr)  key_mem[ent_reg]  <= key_reg;
        if (flag_wr) newf_mem[ent_reg] <= flag_wdata;
        if (ccnt_wr) ccnt_mem[ent_reg] <= ccnt_wdata;
        if (cno_wr)  cno_mem[slot_reg] <= cno_in;
        if (bcnt_wr) bcnt_mem[slot_reg] <= bcnt_wdata;
        if (bmp_wr)  bmp_mem[word_addr] <= bmp_wdata;
    end

    logic [63:0] bit_mask;
    assign bit_mask = 64'd1 << off_in[mbt_pkg::BIT_SEL_W-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    logic [ECW-1:0] total_next;
    logic [ECW-1:0] idx_next;
    logic [EW-1:0]  ent_next;
    logic           found_next;
    logic [CCW-1:0] ccnt_next, k_next;
    logic [SW-1:0]  slot_next;
    logic [WCW-1:0] wc_next;
    logic [31:0]    res_next;
    logic           out_valid_next;
    logic [MAX_ENTRIES-1:0] valid_next;

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        ent_next = ent_reg;
        found_next = found_reg;
        ccnt_next = ccnt_reg;
        k_next = k_reg;
        slot_next = slot_reg;
        wc_next = wc_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        valid_next = valid_reg;
        key_wr = 1'b0; flag_wr = 1'b0; ccnt_wr = 1'b0;
        cno_wr = 1'b0; bcnt_wr = 1'b0; bmp_wr = 1'b0;
        flag_wdata = 1'b0; ccnt_wdata = '0; bcnt_wdata = '0; bmp_wdata = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    idx_next = '0;
                    found_next = 1'b0;
                    if (s_tdata[1:0] == mbt_pkg::OP_MARK_NEW ||
                        s_tdata[1:0] == mbt_pkg::OP_MARK_BLOCK ||
                        s_tdata[1:0] == mbt_pkg::OP_LOOKUP) begin
                        state_next = S_ESCAN;
                    end else begin
                        res_next = pack_res(mbt_pkg::ST_OK, 1'b0, 1'b0, 1'b0, '0, '0,
                                            total_reg);
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_ESCAN: state_next = S_ECHK;
            S_ECHK: begin
                // key_rd holds the entry at idx_reg.
                if (valid_reg[idx_reg[EW-1:0]] && key_rd == key_reg) begin
                    found_next = 1'b1;
                    ent_next = idx_reg[EW-1:0];
                    state_next = S_EREAD;
                end else if (idx_reg == ECW'(MAX_ENTRIES - 1)) begin
                    if (op_reg == mbt_pkg::OP_LOOKUP) begin
                        res_next = pack_res(mbt_pkg::ST_OK, 1'b0, 1'b0, 1'b0, '0, '0,
                                            total_reg);
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end else if (!free_any) begin
                        res_next = pack_res(mbt_pkg::ST_TABLE_FULL, 1'b0, 1'b0, 1'b0,
                                            '0, '0, total_reg);
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        // The entry memories are written in the decode step, once
                        // ent_reg points at the new entry.
                        ent_next = free_idx;
                        valid_next[free_idx] = 1'b1;
                        total_next = total_reg + 1'b1;
                        state_next = S_EDEC;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_ESCAN;
                end
            end
            S_EREAD: state_next = S_EDEC;
            S_EDEC: begin
                if (!found_reg) begin
                    key_wr = 1'b1;
                    flag_wr = 1'b1;
                    flag_wdata = (op_reg == mbt_pkg::OP_MARK_NEW);
                    ccnt_wr = 1'b1;
                    ccnt_wdata = '0;
                end
                case (op_reg)
                    mbt_pkg::OP_MARK_NEW: begin
                        flag_wr = 1'b1;
                        flag_wdata = 1'b1;
                        ccnt_wr = 1'b1;
                        ccnt_wdata = '0;
                        res_next = pack_res(mbt_pkg::ST_OK, found_reg, 1'b1, 1'b0, '0,
                                            '0, total_reg);
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                    mbt_pkg::OP_LOOKUP: begin
                        res_next = pack_res(mbt_pkg::ST_OK, 1'b1, newf_rd, 1'b0, '0,
                                            ccnt_rd, total_reg);
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                    default: begin
                        if (found_reg && newf_rd) begin
                            res_next = pack_res(mbt_pkg::ST_OK, 1'b1, 1'b1, 1'b0, '0,
                                                '0, total_reg);
                            out_valid_next = 1'b1;
                            state_next = S_OUT;
                        end else begin
                            ccnt_next = found_reg ? ccnt_rd : '0;
                            k_next = '0;
                            state_next = S_CSCAN;
                        end
                    end
                endcase
            end
            S_CSCAN: begin
                if (k_reg == ccnt_reg) begin
                    if (ccnt_reg == CCW'(MAX_CONTAINERS)) begin
                        res_next = pack_res(mbt_pkg::ST_SLOTS_FULL, found_reg, 1'b0,
                                            1'b0, '0, ccnt_reg, total_reg);
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        slot_next = SW'(ent_reg) * SW'(MAX_CONTAINERS) + SW'(ccnt_reg);
                        ccnt_next = ccnt_reg + 1'b1;
                        wc_next = '0;
                        state_next = S_CLEAR;
                    end
                end else begin
                    state_next = S_CCHK;
                end
            end
            S_CCHK: begin
                if (cno_rd == cno_in) begin
                    slot_next = slot_rd_addr;
                    state_next = S_WREAD;
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = S_CSCAN;
                end
            end
            S_CLEAR: begin
                bmp_wr = 1'b1;
                bmp_wdata = '0;
                if (wc_reg == WCW'(0)) begin
                    cno_wr = 1'b1;
                    bcnt_wr = 1'b1;
                    bcnt_wdata = '0;
                    ccnt_wr = 1'b1;
                    ccnt_wdata = ccnt_reg;
                end
                if (wc_reg == WCW'(WPS - 1)) begin
                    state_next = S_WREAD;
                end else begin
                    wc_next = wc_reg + 1'b1;
                end
            end
            S_WREAD: state_next = S_WMOD;
            S_WMOD: begin
                if ((word_rd & bit_mask) != '0) begin
                    res_next = pack_res(mbt_pkg::ST_OK, found_reg, 1'b0, 1'b1, bcnt_rd,
                                        ccnt_reg, total_reg);
                end else begin
                    bmp_wr = 1'b1;
                    bmp_wdata = word_rd | bit_mask;
                    bcnt_wr = 1'b1;
                    bcnt_wdata = bcnt_rd + 1'b1;
                    res_next = pack_res(mbt_pkg::ST_OK, found_reg, 1'b0, 1'b0,
                                        bcnt_wdata, ccnt_reg, total_reg);
                end
                out_valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[99:2];
            blk_reg <= s_tdata[131:100];
        end
        idx_reg <= idx_next;
        ent_reg <= ent_next;
        found_reg <= found_next;
        ccnt_reg <= ccnt_next;
        k_reg <= k_next;
        slot_reg <= slot_next;
        wc_reg <= wc_next;
        res_reg <= res_next;
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input ready while result pending");
    a_total_count: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == ECW'($countones(valid_reg))) else $error("entry count mismatch");
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid == (state_reg == S_OUT)) else $error("result valid out of step");
    a_grow_once: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != $past(total_reg) |-> total_reg == $past(total_reg) + 1'b1)
        else $error("entry count jumped");

endmodule
